### hw/rtl/edid_pkg.sv
`timescale 1ns / 1ps

package edid_pkg;

	localparam int NAME_MAX = 13;

	localparam logic [6:0] POS_MAJOR  = 7'd18;
	localparam logic [6:0] POS_MINOR  = 7'd19;
	localparam logic [6:0] DESC_START = 7'd54;
	localparam logic [6:0] DESC_END   = 7'd126;
	localparam logic [6:0] POS_LAST   = 7'd127;

	localparam logic [4:0] DESC_LEN   = 5'd18;
	localparam logic [4:0] OFF_HDR0   = 5'd0;
	localparam logic [4:0] OFF_HDR1   = 5'd1;
	localparam logic [4:0] OFF_TAG    = 5'd3;
	localparam logic [4:0] NAME_SLOT  = 5'd5;

	localparam logic [7:0] NAME_TAG   = 8'hFC;
	localparam logic [7:0] NAME_END   = 8'h0A;
	localparam logic [3:0] NAME_LIMIT = 4'(NAME_MAX);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_SHORT = 2'd1;
	localparam logic [1:0] ST_BAD_SUM   = 2'd2;
	localparam logic [1:0] ST_OLD_VER   = 2'd3;

	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int TDATA_W = 32;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic [7:0] major;
		logic [7:0] minor;
		logic       present;
		logic [3:0] len;
	} edid_event_t;

endpackage

### hw/rtl/edid_base_block_parser_top.sv
// result: the input beat that ends the block or the run sets the emitter busy; the first result
// beat is then registered; name and summary beats follow one per cycle unless m_tready is low
// throughput: one input byte per cycle; input stalls only while a result run of up to
// 14 beats is handed to the output register
// reset: arst_n clears all scan and handshake state asynchronously; the name buffer is not cleared
`timescale 1ns / 1ps

module edid_base_block_parser_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // data_byte
	input  logic                         s_tlast,   // end_of_data
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// name_char[7:0], status[9:8], version_major[17:10], version_minor[25:18],
	// name_present[26], name_length[30:27], zero[31]
	output logic [edid_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tuser,   // result_kind
	output logic                         m_tlast    // last_of_run
);
	import edid_pkg::*;

	edid_event_t evt;
	logic        busy;
	logic        beat;
	logic [3:0]  rd_idx;
	logic [7:0]  rd_data;

	assign s_tready = !busy;
	assign beat     = s_tvalid && s_tready;

	edid_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.data_byte   (s_tdata),
		.end_of_data (s_tlast),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data),
		.evt         (evt)
	);

	edid_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.busy     (busy),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/edid_scan.sv
`timescale 1ns / 1ps

module edid_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               beat,
	input  logic [7:0]         data_byte,
	input  logic               end_of_data,
	input  logic [3:0]         rd_idx,
	output logic [7:0]         rd_data,
	output edid_pkg::edid_event_t evt
);
	import edid_pkg::*;

	logic [6:0] pos_q, pos_d;
	logic       finished_q, finished_d;
	logic [7:0] sum_q, sum_d, sum_add;
	logic [7:0] major_q, major_d;
	logic [7:0] minor_q, minor_d;
	logic [4:0] desc_off_q, desc_off_d;
	logic       hdr_zero_q, hdr_zero_d;
	logic       is_name_q, is_name_d;
	logic       scan_open_q, scan_open_d;
	logic [3:0] name_len_q, name_len_d;
	logic       name_found_q, name_found_d;
	logic [7:0] store_q [NAME_MAX];
	logic       store_we;
	logic       in_desc;
	logic       ver_ok;
	logic       clear_run;

	assign rd_data = store_q[rd_idx];
	assign sum_add = sum_q + data_byte;
	assign in_desc = (pos_q >= DESC_START) && (pos_q < DESC_END);
	assign ver_ok  = (major_q > 8'd1) || ((major_q == 8'd1) && (minor_q >= 8'd4));

	always_comb begin
		pos_d        = pos_q;
		finished_d   = finished_q;
		sum_d        = sum_q;
		major_d      = major_q;
		minor_d      = minor_q;
		desc_off_d   = desc_off_q;
		hdr_zero_d   = hdr_zero_q;
		is_name_d    = is_name_q;
		scan_open_d  = scan_open_q;
		name_len_d   = name_len_q;
		name_found_d = name_found_q;
		store_we     = 1'b0;
		clear_run    = 1'b0;
		evt          = '0;

		if (beat) begin
			if (finished_q) begin
				clear_run = end_of_data;
			end else begin
				sum_d = sum_add;
				if (pos_q == POS_MAJOR) begin
					major_d = data_byte;
				end
				if (pos_q == POS_MINOR) begin
					minor_d = data_byte;
				end

				if (in_desc) begin
					desc_off_d = (desc_off_q == DESC_LEN - 5'd1) ? 5'd0 : desc_off_q + 5'd1;
					case (desc_off_q)
						OFF_HDR0: begin
							hdr_zero_d  = (data_byte == 8'd0);
							is_name_d   = 1'b0;
							scan_open_d = 1'b0;
						end
						OFF_HDR1: begin
							hdr_zero_d = hdr_zero_q && (data_byte == 8'd0);
						end
						OFF_TAG: begin
							is_name_d = hdr_zero_q && (data_byte == NAME_TAG);
							if (hdr_zero_q && (data_byte == NAME_TAG)) begin
								name_found_d = 1'b1;
								name_len_d   = 4'd0;
								scan_open_d  = 1'b1;
							end
						end
						default: begin
							if (desc_off_q >= NAME_SLOT && is_name_q && scan_open_q) begin
								if (data_byte == NAME_END || name_len_q >= NAME_LIMIT) begin
									scan_open_d = 1'b0;
								end else begin
									store_we   = 1'b1;
									name_len_d = name_len_q + 4'd1;
								end
							end
						end
					endcase
				end

				if (pos_q == POS_LAST) begin
					finished_d = 1'b1;
					evt.valid  = 1'b1;
					if (sum_add != 8'd0) begin
						evt.status = ST_BAD_SUM;
					end else if (!ver_ok) begin
						evt.status = ST_OLD_VER;
					end else begin
						evt.status  = ST_OK;
						evt.major   = major_q;
						evt.minor   = minor_q;
						evt.present = name_found_q;
						evt.len     = name_found_q ? name_len_q : 4'd0;
					end
				end else begin
					pos_d = pos_q + 7'd1;
					if (end_of_data) begin
						evt.valid  = 1'b1;
						evt.status = ST_TOO_SHORT;
					end
				end
				clear_run = end_of_data;
			end
		end

		// end of the caller's data starts a fresh run
		if (clear_run) begin
			pos_d        = '0;
			finished_d   = 1'b0;
			sum_d        = '0;
			major_d      = '0;
			minor_d      = '0;
			desc_off_d   = '0;
			hdr_zero_d   = 1'b0;
			is_name_d    = 1'b0;
			scan_open_d  = 1'b0;
			name_len_d   = '0;
			name_found_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			finished_q   <= 1'b0;
			sum_q        <= '0;
			major_q      <= '0;
			minor_q      <= '0;
			desc_off_q   <= '0;
			hdr_zero_q   <= 1'b0;
			is_name_q    <= 1'b0;
			scan_open_q  <= 1'b0;
			name_len_q   <= '0;
			name_found_q <= 1'b0;
		end else begin
			pos_q        <= pos_d;
			finished_q   <= finished_d;
			sum_q        <= sum_d;
			major_q      <= major_d;
			minor_q      <= minor_d;
			desc_off_q   <= desc_off_d;
			hdr_zero_q   <= hdr_zero_d;
			is_name_q    <= is_name_d;
			scan_open_q  <= scan_open_d;
			name_len_q   <= name_len_d;
			name_found_q <= name_found_d;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[name_len_q] <= data_byte;
		end
	end

endmodule

### hw/rtl/edid_emit.sv
`timescale 1ns / 1ps

module edid_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  edid_pkg::edid_event_t          evt,
	output logic                           busy,
	output logic [3:0]                     rd_idx,
	input  logic [7:0]                     rd_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [edid_pkg::TDATA_W-1:0]   m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import edid_pkg::*;

	logic                active_q;
	logic [3:0]          idx_q;
	logic [3:0]          len_q;
	logic [1:0]          status_q;
	logic [7:0]          major_q;
	logic [7:0]          minor_q;
	logic                present_q;
	logic                out_valid_q;
	logic [TDATA_W-1:0]  out_data_q;
	logic                out_kind_q;
	logic                out_last_q;
	logic                slot_free;
	logic                name_step;

	assign slot_free = !out_valid_q || m_tready;
	assign name_step = idx_q < len_q;
	assign busy      = active_q;
	assign rd_idx    = idx_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.valid) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (active_q && slot_free) begin
				if (name_step) begin
					idx_q <= idx_q + 4'd1;
				end else begin
					active_q <= 1'b0;
				end
			end
			if (slot_free) begin
				out_valid_q <= active_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid) begin
			len_q     <= evt.len;
			status_q  <= evt.status;
			major_q   <= evt.major;
			minor_q   <= evt.minor;
			present_q <= evt.present;
		end
		if (slot_free && active_q) begin
			// tdata: name_char, status, major, minor, present, length, pad
			if (name_step) begin
				out_data_q <= {1'b0, 4'd0, 1'b0, 8'd0, 8'd0, ST_OK, rd_data};
				out_kind_q <= KIND_NAME;
				out_last_q <= 1'b0;
			end else begin
				out_data_q <= {1'b0, len_q, present_q, minor_q, major_q, status_q, 8'd0};
				out_kind_q <= KIND_SUMMARY;
				out_last_q <= 1'b1;
			end
		end
	end

endmodule
